// ----- hdl/belr_pkg.sv -----
// ----------------------------------------------------------------------------
// belr_pkg
// Shared types, class codes and helpers for the bidi explicit level resolver.
// ----------------------------------------------------------------------------
package belr_pkg;

	localparam int DEPTH_LIMIT_DEF = 125;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int LEVEL_W = 7;
	localparam int CLASS_W = 5;
	localparam int OV_W    = 2;
	localparam int VI_W    = 7;

	localparam logic [CLASS_W-1:0] CLS_L   = 5'd0;
	localparam logic [CLASS_W-1:0] CLS_R   = 5'd1;
	localparam logic [CLASS_W-1:0] CLS_BN  = 5'd9;
	localparam logic [CLASS_W-1:0] CLS_B   = 5'd10;
	localparam logic [CLASS_W-1:0] CLS_LRE = 5'd14;
	localparam logic [CLASS_W-1:0] CLS_LRO = 5'd15;
	localparam logic [CLASS_W-1:0] CLS_RLE = 5'd16;
	localparam logic [CLASS_W-1:0] CLS_RLO = 5'd17;
	localparam logic [CLASS_W-1:0] CLS_PDF = 5'd18;
	localparam logic [CLASS_W-1:0] CLS_LRI = 5'd19;
	localparam logic [CLASS_W-1:0] CLS_RLI = 5'd20;
	localparam logic [CLASS_W-1:0] CLS_FSI = 5'd21;
	localparam logic [CLASS_W-1:0] CLS_PDI = 5'd22;

	localparam logic [OV_W-1:0] OV_NONE = 2'd0;
	localparam logic [OV_W-1:0] OV_L    = 2'd1;
	localparam logic [OV_W-1:0] OV_R    = 2'd2;

	localparam logic REG_PARAGRAPH_LEVEL = 1'b0;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [OV_W-1:0]    ov;
		logic               iso;
	} stack_ent_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic pop_step;
		logic load_top;
		logic pdi_out;
	} belr_cmd_t;

	typedef struct packed {
		logic pdi_pop;
		logic refill;
		logic cnt_gt1;
		logic top_iso;
		logic out_free;
	} belr_sts_t;

	function automatic logic [CLASS_W-1:0] apply_override(
		input logic [CLASS_W-1:0] cls,
		input logic [OV_W-1:0]    ov
	);
		logic [CLASS_W-1:0] res;
		res = cls;
		if (ov == OV_L) begin
			res = CLS_L;
		end else if (ov == OV_R) begin
			res = CLS_R;
		end
		return res;
	endfunction

endpackage

// ----- hdl/belr_ctrl.sv -----
// ----------------------------------------------------------------------------
// belr_ctrl
// Sequencer: accepts an item, runs its step, walks stack pops and reloads the top of stack.
// ----------------------------------------------------------------------------
module belr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  belr_pkg::belr_sts_t sts,
	output belr_pkg::belr_cmd_t cmd
);
	import belr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_EXEC    = 6'b000010,
		ST_POP_CHK = 6'b000100,
		ST_POP_LD  = 6'b001000,
		ST_PDI_OUT = 6'b010000,
		ST_REFILL  = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	logic   pop_last_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					if (sts.pdi_pop) begin
						state_nx = ST_POP_CHK;
					end else if (sts.refill) begin
						state_nx = ST_REFILL;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_POP_CHK: begin
				if (sts.cnt_gt1) begin
					cmd.pop_step = 1'b1;
					state_nx     = ST_POP_LD;
				end else begin
					state_nx = ST_PDI_OUT;
				end
			end
			ST_POP_LD: begin
				cmd.load_top = 1'b1;
				state_nx     = pop_last_q ? ST_PDI_OUT : ST_POP_CHK;
			end
			ST_PDI_OUT: begin
				if (sts.out_free) begin
					cmd.pdi_out = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			ST_REFILL: begin
				cmd.load_top = 1'b1;
				state_nx     = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pop_last_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.pop_step) begin
				pop_last_q <= sts.top_iso;
			end
		end
	end

endmodule

// ----- hdl/belr_dp.sv -----
// ----------------------------------------------------------------------------
// belr_dp
// Datapath: directional status stack, overflow counters and result register.
// ----------------------------------------------------------------------------
module belr_dp #(
	parameter int DEPTH_LIMIT = belr_pkg::DEPTH_LIMIT_DEF,
	parameter int COUNT_WIDTH = belr_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  belr_pkg::belr_cmd_t           cmd,
	output belr_pkg::belr_sts_t           sts,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          para_level,
	input  logic [belr_pkg::CLASS_W-1:0]  in_class,
	input  logic                          in_fsi,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [belr_pkg::LEVEL_W-1:0]  out_level,
	output logic [belr_pkg::CLASS_W-1:0]  out_class,
	output logic                          out_removed
);
	import belr_pkg::*;

	localparam int STACK_DEPTH = DEPTH_LIMIT + 2;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	stack_ent_t mem [STACK_DEPTH];

	logic [CLASS_W-1:0]     cls_q;
	logic                   fsi_q;
	logic                   last_q;
	logic                   para_q;
	stack_ent_t             top_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [COUNT_WIDTH-1:0] oi_q;
	logic [COUNT_WIDTH-1:0] oe_q;
	logic [VI_W-1:0]        vi_q;
	stack_ent_t             rd_q;
	logic                   rd_zero_q;
	logic                   ovld_q;
	logic [LEVEL_W-1:0]     olvl_q;
	logic [CLASS_W-1:0]     ocls_q;
	logic                   orem_q;

	logic [LEVEL_W:0]       cur_w, nodd, neven, nl;
	logic                   cnt_gt1, oi_zero, oe_zero, can_push;
	logic                   push_en, oi_inc, oi_dec, oe_inc, oe_dec, oe_clr;
	logic                   vi_inc, vi_dec, cnt_dec, reset_after;
	stack_ent_t             push_ent, rd_ent;
	logic [LEVEL_W-1:0]     ex_lvl;
	logic [CLASS_W-1:0]     ex_cls;
	logic                   ex_rem;
	logic [IDX_W-1:0]       rd_addr;
	logic                   out_wr, para_rst, para_nx;
	logic                   pdi_pop, pdf_pop;
	logic [CNT_W-1:0]       cnt_m2;

	assign cnt_gt1 = cnt_q > CNT_W'(1);
	assign oi_zero = oi_q == '0;
	assign oe_zero = oe_q == '0;
	assign cur_w   = {1'b0, top_q.level};
	assign nodd    = top_q.level[0] ? cur_w + (LEVEL_W+1)'(2) : cur_w + (LEVEL_W+1)'(1);
	assign neven   = top_q.level[0] ? cur_w + (LEVEL_W+1)'(1) : cur_w + (LEVEL_W+1)'(2);

	assign pdi_pop = (cls_q == CLS_PDI) && oi_zero && (vi_q != '0);
	assign pdf_pop = (cls_q == CLS_PDF) && oi_zero && oe_zero && !top_q.iso && cnt_gt1;

	always_comb begin
		nl       = neven;
		push_en  = 1'b0;
		push_ent = '{level: nl[LEVEL_W-1:0], ov: OV_NONE, iso: 1'b0};
		oi_inc   = 1'b0;
		oi_dec   = 1'b0;
		oe_inc   = 1'b0;
		oe_dec   = 1'b0;
		oe_clr   = 1'b0;
		vi_inc   = 1'b0;
		vi_dec   = 1'b0;
		cnt_dec  = 1'b0;
		ex_lvl   = top_q.level;
		ex_cls   = apply_override(cls_q, top_q.ov);
		ex_rem   = 1'b0;
		reset_after = last_q;
		case (cls_q) inside
			CLS_LRE, CLS_LRO, CLS_RLE, CLS_RLO: begin
				nl = ((cls_q == CLS_RLE) || (cls_q == CLS_RLO)) ? nodd : neven;
				push_ent.level = nl[LEVEL_W-1:0];
				push_ent.ov    = (cls_q == CLS_RLO) ? OV_R :
					((cls_q == CLS_LRO) ? OV_L : OV_NONE);
				push_ent.iso   = 1'b0;
				if (can_push) begin
					push_en = 1'b1;
				end else if (oi_zero) begin
					oe_inc = 1'b1;
				end
				ex_lvl = '0;
				ex_cls = cls_q;
				ex_rem = 1'b1;
			end
			CLS_LRI, CLS_RLI, CLS_FSI: begin
				nl = ((cls_q == CLS_RLI) || ((cls_q == CLS_FSI) && fsi_q)) ? nodd : neven;
				push_ent.level = nl[LEVEL_W-1:0];
				push_ent.ov    = OV_NONE;
				push_ent.iso   = 1'b1;
				if (can_push) begin
					push_en = 1'b1;
					vi_inc  = 1'b1;
				end else begin
					oi_inc = 1'b1;
				end
			end
			CLS_PDI: begin
				if (!oi_zero) begin
					oi_dec = 1'b1;
				end else if (vi_q != '0) begin
					oe_clr = 1'b1;
					vi_dec = 1'b1;
				end
			end
			CLS_PDF: begin
				if (oi_zero) begin
					if (!oe_zero) begin
						oe_dec = 1'b1;
					end else if (pdf_pop) begin
						cnt_dec = 1'b1;
					end
				end
				ex_lvl = '0;
				ex_cls = cls_q;
				ex_rem = 1'b1;
			end
			CLS_B: begin
				ex_lvl      = LEVEL_W'(para_q);
				ex_cls      = cls_q;
				reset_after = 1'b1;
			end
			CLS_BN: begin
				ex_lvl = '0;
				ex_cls = cls_q;
				ex_rem = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign can_push = (nl <= (LEVEL_W+1)'(DEPTH_LIMIT)) && oi_zero && oe_zero
		&& (cnt_q < CNT_W'(STACK_DEPTH));

	assign cnt_m2  = cnt_q - CNT_W'(2);
	assign rd_addr = cnt_gt1 ? cnt_m2[IDX_W-1:0] : '0;
	assign rd_ent  = rd_zero_q ? '{level: LEVEL_W'(para_q), ov: OV_NONE, iso: 1'b0} : rd_q;

	assign out_wr   = (cmd.exec && !pdi_pop) || cmd.pdi_out;
	assign para_nx  = cfg_we ? cfg_wdata : para_q;
	assign para_rst = cfg_we || (cmd.exec && !pdi_pop && reset_after)
		|| (cmd.pdi_out && last_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cls_q  <= in_class;
			fsi_q  <= in_fsi;
			last_q <= in_last;
		end
		if (cmd.exec && push_en) begin
			mem[cnt_q[IDX_W-1:0]] <= push_ent;
		end
		rd_q      <= mem[rd_addr];
		rd_zero_q <= !cnt_gt1 || (cnt_q == CNT_W'(2));
		if (out_wr) begin
			if (cmd.exec) begin
				olvl_q <= ex_lvl;
				ocls_q <= ex_cls;
				orem_q <= ex_rem;
			end else begin
				olvl_q <= top_q.level;
				ocls_q <= apply_override(cls_q, top_q.ov);
				orem_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			para_q <= 1'b0;
			ovld_q <= 1'b0;
			cnt_q  <= CNT_W'(1);
			oi_q   <= '0;
			oe_q   <= '0;
			vi_q   <= '0;
			top_q  <= '{level: '0, ov: OV_NONE, iso: 1'b0};
		end else begin
			if (cfg_we) begin
				para_q <= cfg_wdata;
			end
			if (out_wr) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
			if (para_rst) begin
				cnt_q <= CNT_W'(1);
				oi_q  <= '0;
				oe_q  <= '0;
				vi_q  <= '0;
				top_q <= '{level: LEVEL_W'(para_nx), ov: OV_NONE, iso: 1'b0};
			end else begin
				if (cmd.exec) begin
					if (push_en) begin
						top_q <= push_ent;
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (cnt_dec) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
					if (oi_inc && (oi_q != '1)) begin
						oi_q <= oi_q + COUNT_WIDTH'(1);
					end
					if (oi_dec) begin
						oi_q <= oi_q - COUNT_WIDTH'(1);
					end
					if (oe_clr) begin
						oe_q <= '0;
					end else if (oe_inc && (oe_q != '1)) begin
						oe_q <= oe_q + COUNT_WIDTH'(1);
					end else if (oe_dec) begin
						oe_q <= oe_q - COUNT_WIDTH'(1);
					end
					if (vi_inc) begin
						vi_q <= vi_q + VI_W'(1);
					end
					if (vi_dec) begin
						vi_q <= vi_q - VI_W'(1);
					end
				end
				if (cmd.pop_step) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (cmd.load_top) begin
					top_q <= rd_ent;
				end
			end
		end
	end

	assign sts.pdi_pop  = pdi_pop;
	assign sts.refill   = pdf_pop && !last_q;
	assign sts.cnt_gt1  = cnt_gt1;
	assign sts.top_iso  = top_q.iso;
	assign sts.out_free = !ovld_q || out_ready;

	assign para_level  = para_q;
	assign out_valid   = ovld_q;
	assign out_level   = olvl_q;
	assign out_class   = ocls_q;
	assign out_removed = orem_q;

endmodule

// ----- hdl/bidi_explicit_level_resolver.sv -----
// ----------------------------------------------------------------------------
// bidi_explicit_level_resolver
// Explicit embedding level resolution (bidi rules X1 to X8), one class per item.
// ----------------------------------------------------------------------------
// input stream: s_tdata carries the bidi class and the fsi direction bit,
// s_tlast marks the last character of the paragraph
// output stream: m_tdata carries the resolved level and the class after
// override, m_tuser flags the explicit codes that are removed later
// apb port: register 0 is the paragraph level; a write also restarts the
// paragraph state, pready is tied high
// an item is taken in the idle state and executed in the execute state once
// the result register is free; the result is registered and shows on
// m_tvalid in the cycle after execution; a pdf that pops adds a refill state:
// the new top of stack comes back through the registered read port of the
// stack memory; a pdi that closes an isolate adds a check and a load state per
// popped stack entry, one read and one reload of the top of stack per entry
// s_tready is high only between items; a stalled receiver holds the result
// register and the next item waits in its execute cycle until it is taken
// reset: paragraph level 0, stack holds one entry, counters cleared; entry
// zero lives in flops so the stack memory needs no clearing pass
// ----------------------------------------------------------------------------
module bidi_explicit_level_resolver #(
	parameter int DEPTH_LIMIT = belr_pkg::DEPTH_LIMIT_DEF,
	parameter int COUNT_WIDTH = belr_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] char class, [5] fsi_is_rtl
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] level, [11:7] out_class
	output logic        m_tuser,   // [0] removed_code
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import belr_pkg::*;

	belr_cmd_t          cmd;
	belr_sts_t          sts;
	logic               cfg_we;
	logic               para_level;
	logic [LEVEL_W-1:0] out_level;
	logic [CLASS_W-1:0] out_class;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_PARAGRAPH_LEVEL);
	assign prdata = (paddr[2] == REG_PARAGRAPH_LEVEL) ? {31'b0, para_level} : '0;

	belr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	belr_dp #(
		.DEPTH_LIMIT (DEPTH_LIMIT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[0]),
		.para_level  (para_level),
		.in_class    (s_tdata[4:0]),
		.in_fsi      (s_tdata[5]),
		.in_last     (s_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_level   (out_level),
		.out_class   (out_class),
		.out_removed (m_tuser)
	);

	assign m_tdata = {4'b0, out_class, out_level};

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in flight");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_step |-> sts.cnt_gt1)
		else $error("pop of the base stack entry");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.pdi_out) |-> sts.out_free)
		else $error("result register overwritten while held");

	a_pop_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_step |=> cmd.load_top)
		else $error("stack pop not followed by top reload");

endmodule

// ----- bench/bidi_explicit_level_resolver_tb.sv -----
// ----------------------------------------------------------------------------
// bidi_explicit_level_resolver_tb
// Self-checking bench for the explicit embedding level resolver.
// ----------------------------------------------------------------------------
// Characters go in on the input stream. Each accepted item runs through a
// predictor of rules X1 to X8 that keeps its own status stack and counters.
// The prediction, or the typed result of a table row marked known, is queued
// and compared field by field with every result taken from the output stream.
// A short table of hand-picked characters comes first.
// Random paragraphs follow, some of them nested deep enough to overflow.
// Between random phases, a burst without stalls pushes to the deepest level and overflows both counters.
// The paragraph level is rewritten over the APB port between phases.
// Both streams stall at random.
// ----------------------------------------------------------------------------
module bidi_explicit_level_resolver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import belr_pkg::*;

	localparam int MAX_D   = DEPTH_LIMIT_DEF;
	localparam int COUNT_W = COUNT_WIDTH_DEF;
	localparam int STACK_N = MAX_D + 2;
	localparam int LIMIT   = 2000000;
	localparam int OVF_RUN = 40;

	localparam logic [2:0] ADDR_PARA_LEVEL = 3'(4 * REG_PARAGRAPH_LEVEL);

	localparam logic [CLASS_W-1:0] CLS_AL        = 5'd2;
	localparam logic [CLASS_W-1:0] CLS_EN        = 5'd3;
	localparam logic [CLASS_W-1:0] CLS_ES        = 5'd4;
	localparam logic [CLASS_W-1:0] CLS_ET        = 5'd5;
	localparam logic [CLASS_W-1:0] CLS_AN        = 5'd6;
	localparam logic [CLASS_W-1:0] CLS_CS        = 5'd7;
	localparam logic [CLASS_W-1:0] CLS_NSM       = 5'd8;
	localparam logic [CLASS_W-1:0] CLS_S         = 5'd11;
	localparam logic [CLASS_W-1:0] CLS_WS        = 5'd12;
	localparam logic [CLASS_W-1:0] CLS_ON        = 5'd13;
	localparam logic [CLASS_W-1:0] CLS_UNK_FIRST = 5'd23;
	localparam logic [CLASS_W-1:0] CLS_UNK_LAST  = 5'd31;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [CLASS_W-1:0] cls;
		logic               removed;
	} char_res_t;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               fsi;
		logic               last;
		logic               known;
		logic [LEVEL_W-1:0] level;
		logic [CLASS_W-1:0] ocls;
		logic               removed;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [4:0] char class, [5] fsi_is_rtl
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [6:0] level, [11:7] out_class
	logic        m_tuser;   // [0] removed_code
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bidi_explicit_level_resolver #(
		.DEPTH_LIMIT (MAX_D),
		.COUNT_WIDTH (COUNT_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state
	logic               para_lvl;
	logic [LEVEL_W-1:0] lvl_stk [STACK_N];
	logic [OV_W-1:0]    ovr_stk [STACK_N];
	logic               iso_stk [STACK_N];
	int unsigned        depth;
	logic [COUNT_W-1:0] ovf_iso;
	logic [COUNT_W-1:0] ovf_emb;
	int unsigned        open_iso;

	char_res_t pending_levels [$];
	int        errors = 0;
	int        cycles = 0;
	bit        calm = 1'b0;

	logic [CLASS_W-1:0] plain_classes [12] = '{CLS_L, CLS_R, CLS_AL, CLS_EN, CLS_ES,
		CLS_ET, CLS_AN, CLS_CS, CLS_NSM, CLS_S, CLS_WS, CLS_ON};

	plan_row_t plan [24] = '{
		'{CLS_L,   1'b0, 1'b0, 1'b1, 7'd0, CLS_L,   1'b0},
		'{CLS_BN,  1'b0, 1'b0, 1'b1, 7'd0, CLS_BN,  1'b1},
		'{CLS_RLE, 1'b0, 1'b0, 1'b1, 7'd0, CLS_RLE, 1'b1},
		'{CLS_L,   1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_RLO, 1'b0, 1'b0, 1'b1, 7'd0, CLS_RLO, 1'b1},
		'{CLS_EN,  1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_LRO, 1'b0, 1'b0, 1'b1, 7'd0, CLS_LRO, 1'b1},
		'{CLS_AL,  1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_PDF, 1'b0, 1'b0, 1'b1, 7'd0, CLS_PDF, 1'b1},
		'{CLS_LRE, 1'b1, 1'b0, 1'b1, 7'd0, CLS_LRE, 1'b1},
		'{CLS_RLI, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_ON,  1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_FSI, 1'b1, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_FSI, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_PDI, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_UNK_LAST,  1'b1, 1'b0, 1'b0, 7'd0, CLS_L, 1'b0},
		'{CLS_UNK_FIRST, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L, 1'b0},
		'{CLS_PDI, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_PDF, 1'b0, 1'b0, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_S,   1'b0, 1'b1, 1'b0, 7'd0, CLS_L,   1'b0},
		'{CLS_PDI, 1'b0, 1'b0, 1'b1, 7'd0, CLS_PDI, 1'b0},
		'{CLS_PDF, 1'b1, 1'b0, 1'b1, 7'd0, CLS_PDF, 1'b1},
		'{CLS_B,   1'b0, 1'b0, 1'b1, 7'd0, CLS_B,   1'b0},
		'{CLS_WS,  1'b1, 1'b0, 1'b1, 7'd0, CLS_WS,  1'b0}
	};

	function automatic void clear_paragraph();
		for (int k = 0; k < STACK_N; k++) begin
			lvl_stk[k] = '0;
			ovr_stk[k] = OV_NONE;
			iso_stk[k] = 1'b0;
		end
		lvl_stk[0] = {{(LEVEL_W-1){1'b0}}, para_lvl};
		depth = 1;
		ovf_iso = '0;
		ovf_emb = '0;
		open_iso = 0;
	endfunction

	function automatic bit room_for(input int unsigned nl);
		return nl <= MAX_D && ovf_iso == 0 && ovf_emb == 0 && depth < STACK_N;
	endfunction

	function automatic logic [CLASS_W-1:0] overridden(input logic [CLASS_W-1:0] cls,
			input logic [OV_W-1:0] ov);
		if (ov == OV_L) begin
			return CLS_L;
		end else if (ov == OV_R) begin
			return CLS_R;
		end
		return cls;
	endfunction

	function automatic char_res_t resolve_level(input logic [CLASS_W-1:0] cls, input bit fsi,
			input bit last);
		char_res_t   r;
		int unsigned cur, nodd, neven, nl;
		logic [OV_W-1:0] cur_ov, ov;
		bit          reset_after;
		cur = lvl_stk[depth-1];
		cur_ov = ovr_stk[depth-1];
		nodd = cur[0] ? cur + 2 : cur + 1;
		neven = cur[0] ? cur + 1 : cur + 2;
		r.level = '0;
		r.cls = cls;
		r.removed = 1'b0;
		reset_after = last;
		case (cls) inside
			CLS_RLE, CLS_LRE, CLS_RLO, CLS_LRO: begin
				nl = (cls == CLS_RLE || cls == CLS_RLO) ? nodd : neven;
				ov = (cls == CLS_RLO) ? OV_R : ((cls == CLS_LRO) ? OV_L : OV_NONE);
				if (room_for(nl)) begin
					lvl_stk[depth] = LEVEL_W'(nl);
					ovr_stk[depth] = ov;
					iso_stk[depth] = 1'b0;
					depth++;
				end else if (ovf_iso == 0 && ovf_emb != '1) begin
					ovf_emb++;
				end
				r.removed = 1'b1;
			end
			CLS_RLI, CLS_LRI, CLS_FSI: begin
				nl = (cls == CLS_RLI || (cls == CLS_FSI && fsi)) ? nodd : neven;
				r.level = LEVEL_W'(cur);
				r.cls = overridden(cls, cur_ov);
				if (room_for(nl)) begin
					open_iso++;
					lvl_stk[depth] = LEVEL_W'(nl);
					ovr_stk[depth] = OV_NONE;
					iso_stk[depth] = 1'b1;
					depth++;
				end else if (ovf_iso != '1) begin
					ovf_iso++;
				end
			end
			CLS_PDI: begin
				if (ovf_iso != 0) begin
					ovf_iso--;
				end else if (open_iso > 0) begin
					ovf_emb = '0;
					while (depth > 1 && !iso_stk[depth-1]) depth--;
					if (depth > 1) depth--;
					open_iso--;
				end
				r.level = lvl_stk[depth-1];
				r.cls = overridden(cls, ovr_stk[depth-1]);
			end
			CLS_PDF: begin
				if (ovf_iso != 0) begin
				end else if (ovf_emb != 0) begin
					ovf_emb--;
				end else if (!iso_stk[depth-1] && depth >= 2) begin
					depth--;
				end
				r.removed = 1'b1;
			end
			CLS_B: begin
				r.level = {{(LEVEL_W-1){1'b0}}, para_lvl};
				reset_after = 1'b1;
			end
			CLS_BN: begin
				r.removed = 1'b1;
			end
			default: begin
				r.level = LEVEL_W'(cur);
				r.cls = overridden(cls, cur_ov);
			end
		endcase
		if (reset_after) clear_paragraph();
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic send_char(input logic [CLASS_W-1:0] cls, input bit fsi, input bit last,
			input bit known, input char_res_t typed);
		char_res_t pred;
		if (!calm) begin
			while ($urandom_range(99) < 33) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, fsi, cls};
		s_tlast <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		pred = resolve_level(cls, fsi, last);
		pending_levels.insert(pending_levels.size(), known ? typed : pred);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_paragraph_level(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PARA_LEVEL;
		pwdata <= {31'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		para_lvl = v;
		clear_paragraph();
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== {31'b0, v})
			report($sformatf("paragraph level reads %0h, wrote %0d", prdata, v));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// pushes to the deepest level, keeps overflowing for a while, then sends six closing codes and ends the paragraph
	task automatic overflow_burst(input bit isolates);
		for (int k = 0; k < MAX_D; k++) begin
			if (isolates)
				send_char((k % 2 == 0) ? CLS_RLI : CLS_LRI, 1'($urandom_range(1)), 1'b0,
					1'b0, '0);
			else
				send_char((k % 2 == 0) ? CLS_RLE : CLS_LRE, 1'($urandom_range(1)), 1'b0,
					1'b0, '0);
		end
		for (int k = 0; k < OVF_RUN; k++) begin
			if (isolates)
				send_char(CLS_LRI + 5'($urandom_range(2)), 1'($urandom_range(1)), 1'b0,
					1'b0, '0);
			else
				send_char(CLS_LRE + 5'($urandom_range(3)), 1'($urandom_range(1)), 1'b0,
					1'b0, '0);
		end
		for (int k = 0; k < 6; k++)
			send_char(isolates ? CLS_PDI : CLS_PDF, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
		send_char(CLS_L, 1'b0, 1'b1, 1'b0, '0);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned        sent, n, r;
		bit                 deep, last;
		logic [CLASS_W-1:0] cls;
		sent = 0;
		while (sent < count) begin
			deep = ($urandom_range(11) == 0);
			calm = ($urandom_range(7) == 0);
			n = deep ? $urandom_range(200, 130) : $urandom_range(40, 1);
			for (int j = 0; j < n; j++) begin
				r = $urandom_range(99);
				if (deep && r < 70) begin
					if (r < 35) cls = CLS_LRE + 5'($urandom_range(3));
					else cls = CLS_LRI + 5'($urandom_range(2));
				end else if (r < 35) begin
					cls = plain_classes[$urandom_range(11)];
				end else if (r < 38) begin
					cls = 5'($urandom_range(CLS_UNK_LAST, CLS_UNK_FIRST));
				end else if (r < 41) begin
					cls = CLS_BN;
				end else if (r < 55) begin
					cls = CLS_LRE + 5'($urandom_range(3));
				end else if (r < 67) begin
					cls = CLS_LRI + 5'($urandom_range(2));
				end else if (r < 79) begin
					cls = CLS_PDF;
				end else if (r < 91) begin
					cls = CLS_PDI;
				end else if (r < 93) begin
					cls = CLS_B;
				end else begin
					cls = plain_classes[$urandom_range(11)];
				end
				last = (j == n - 1) ? ($urandom_range(4) != 0) : ($urandom_range(99) == 0);
				send_char(cls, 1'($urandom_range(1)), last, 1'b0, '0);
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		char_res_t got, want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got.level = m_tdata[6:0];
				got.cls = m_tdata[11:7];
				got.removed = m_tuser;
				if (pending_levels.size() == 0) begin
					report($sformatf("result with no item pending, level %0d class %0d",
						got.level, got.cls));
				end else begin
					want = pending_levels.pop_front();
					if (got.level !== want.level)
						report($sformatf("level %0d, expected %0d", got.level, want.level));
					if (got.cls !== want.cls)
						report($sformatf("out_class %0d, expected %0d", got.cls, want.cls));
					if (got.removed !== want.removed)
						report($sformatf("removed_code %0b, expected %0b", got.removed,
							want.removed));
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 33);
		end
	end

	initial begin
		char_res_t typed;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		para_lvl = 1'b0;
		clear_paragraph();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			typed.level = plan[i].level;
			typed.cls = plan[i].ocls;
			typed.removed = plan[i].removed;
			send_char(plan[i].cls, plan[i].fsi, plan[i].last, plan[i].known, typed);
		end
		drain();

		set_paragraph_level(1'b1);
		run_random(375);
		drain();

		set_paragraph_level(1'b0);
		calm = 1'b1;
		overflow_burst(1'b0);
		overflow_burst(1'b1);
		calm = 1'b0;
		drain();

		set_paragraph_level(1'b1);
		run_random(375);
		drain();

		set_paragraph_level(1'b0);
		run_random(375);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
